// ===== hw/rtl/udp_length_and_checksum_update_defines.svh =====
// Assertion macros for the UDP length and checksum update block.
// Used by the top level only; no other dependencies.
// Both forms run at the rising edge of the given clock and stay off during reset.
`ifndef UDP_LENGTH_AND_CHECKSUM_UPDATE_DEFINES_SVH
`define UDP_LENGTH_AND_CHECKSUM_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
// Implication or plain property, checked at each rising edge out of reset
`define ULCU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ulcu assertion failed");
// Condition that must never be true out of reset
`define ULCU_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ulcu forbidden condition seen");
`else
`define ULCU_ASSERT(label, clk, rst_n, prop)
`define ULCU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/ulcu_pkg.sv =====
// Shared types, constants and checksum helpers for the UDP length and checksum update.
// No dependencies; used by ulcu_hdr_calc and the top level.
package ulcu_pkg;

	// Item kinds on the input tuser
	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// Stream widths
	localparam int IN_DATA_W  = 176;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 2;

	// Seed sum: eight 16-bit terms plus the protocol number fit in 20 bits
	localparam int SEED_W = 20;

	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] PROTO_UDP     = 16'd17;

	// Header arithmetic handed from the header calculator to the top level
	typedef struct packed {
		logic              same_len;
		logic              too_short;
		logic              no_payload;
		logic [15:0]       new_tot;
		logic [15:0]       ip_csum;
		logic [15:0]       payload_bytes;
		logic [SEED_W-1:0] seed;
	} hdr_calc_t;

	// End-around-carry fold of a 32-bit sum; two passes always settle it
	function automatic logic [15:0] fold32(input logic [31:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = {1'b0, s[31:16]} + {1'b0, s[15:0]};
		b = {1'b0, a[15:0]} + {16'b0, a[16]};
		return b[15:0];
	endfunction

	// Final UDP checksum: complement of the fold, zero sent as all ones
	function automatic logic [15:0] udp_finish(input logic [31:0] s);
		logic [15:0] c;
		c = ~fold32(s);
		return (c == 16'h0000) ? 16'hffff : c;
	endfunction

endpackage

// ===== hw/rtl/ulcu_hdr_calc.sv =====
// Header arithmetic: new IP total length, incremental IP checksum and UDP seed sum.
// Depends on ulcu_pkg.
module ulcu_hdr_calc (
	input  logic [31:0]          src_address,
	input  logic [31:0]          dst_address,
	input  logic [15:0]          old_ip_total_length,
	input  logic [15:0]          old_ip_checksum,
	input  logic [15:0]          old_udp_length,
	input  logic [15:0]          new_udp_length,
	input  logic [15:0]          src_port,
	input  logic [15:0]          dst_port,
	output ulcu_pkg::hdr_calc_t  calc
);

	logic [15:0] new_tot;
	logic [15:0] inv_chk;
	logic [15:0] inv_tot;
	logic [17:0] ip_sum;
	logic [ulcu_pkg::SEED_W-1:0] seed;

	// Total length moves by the UDP length delta, wrapping at 16 bits
	assign new_tot = old_ip_total_length + new_udp_length - old_udp_length;

	// Incremental update: ~(~HC + ~m + m')
	assign inv_chk = ~old_ip_checksum;
	assign inv_tot = ~old_ip_total_length;
	assign ip_sum  = {2'b00, inv_chk} + {2'b00, inv_tot} + {2'b00, new_tot};

	// Pseudo-header plus UDP header; length counted twice, checksum as zero
	always_comb begin
		seed = {4'h0, src_address[31:16]} + {4'h0, src_address[15:0]}
			+ {4'h0, dst_address[31:16]} + {4'h0, dst_address[15:0]}
			+ {4'h0, ulcu_pkg::PROTO_UDP} + {4'h0, new_udp_length}
			+ {4'h0, src_port} + {4'h0, dst_port} + {4'h0, new_udp_length};
	end

	always_comb begin
		calc.same_len      = (old_udp_length == new_udp_length);
		calc.too_short     = (new_udp_length < ulcu_pkg::UDP_HDR_BYTES);
		calc.no_payload    = (new_udp_length == ulcu_pkg::UDP_HDR_BYTES);
		calc.new_tot       = new_tot;
		calc.ip_csum       = ~ulcu_pkg::fold32({14'h0, ip_sum});
		calc.payload_bytes = new_udp_length - ulcu_pkg::UDP_HDR_BYTES;
		calc.seed          = seed;
	end

endmodule

// ===== hw/rtl/udp_length_and_checksum_update.sv =====
// Top level of the UDP length and checksum update block.
// Depends on ulcu_pkg, ulcu_hdr_calc and udp_length_and_checksum_update_defines.svh.
//
// A header request starts a packet and a payload request brings one big-endian
// 16-bit word. Requests are taken one per cycle while the output register is
// free or draining; each passes an input register, then the arithmetic (the
// 32-bit running sum plus its fold and complement), and its result, if any,
// sits in the output register. Unchanged lengths and new lengths of at most
// eight bytes answer on the header itself; longer packets answer on the
// payload word that uses up the byte count, and an odd count uses only the
// high byte of the last word. Payload words that arrive with no bytes
// outstanding are dropped silently.
`include "udp_length_and_checksum_update_defines.svh"

module udp_length_and_checksum_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// src_address, dst_address, old_ip_total_length, old_ip_checksum,
	// old_udp_length, new_udp_length, src_port, dst_port, payload_word
	input  logic [ulcu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// opcode
	input  logic [ulcu_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// new_ip_total_length, new_ip_checksum, new_udp_checksum
	output logic [ulcu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// changed, length_too_short
	output logic [ulcu_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

	// Input register
	logic                             valid_s1;
	logic [ulcu_pkg::IN_DATA_W-1:0]   tdata_s1;
	logic                             opcode_s1;

	// Packet state
	logic [31:0] acc_q;
	logic [15:0] bytes_left_q;
	logic [15:0] held_tot_q;
	logic [15:0] held_ipc_q;

	// Output register
	logic                             m_valid_q;
	logic [ulcu_pkg::OUT_DATA_W-1:0]  m_data_q;
	logic [ulcu_pkg::OUT_USER_W-1:0]  m_user_q;

	logic advance;
	logic fire_s1;

	ulcu_pkg::hdr_calc_t calc;

	logic [15:0] payload_word;
	logic [15:0] pay_w;
	logic [31:0] pay_sum;

	logic [31:0] acc_d;
	logic [15:0] bytes_left_d;
	logic [15:0] held_tot_d;
	logic [15:0] held_ipc_d;
	logic        emit;
	logic        r_changed;
	logic        r_short;
	logic [15:0] r_tot;
	logic [15:0] r_ipc;
	logic [15:0] r_udp;

	// Handshake: stage 1 moves whenever the output register is free or draining
	assign advance       = !m_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tdata_s1  <= s_axis_tdata;
			opcode_s1 <= s_axis_tuser[0];
		end
	end

	ulcu_hdr_calc u_hdr_calc (
		.src_address         (tdata_s1[31:0]),
		.dst_address         (tdata_s1[63:32]),
		.old_ip_total_length (tdata_s1[79:64]),
		.old_ip_checksum     (tdata_s1[95:80]),
		.old_udp_length      (tdata_s1[111:96]),
		.new_udp_length      (tdata_s1[127:112]),
		.src_port            (tdata_s1[143:128]),
		.dst_port            (tdata_s1[159:144]),
		.calc                (calc)
	);

	// Payload word; a lone last byte keeps only the high half
	assign payload_word = tdata_s1[175:160];
	assign pay_w        = (bytes_left_q == 16'd1) ? {payload_word[15:8], 8'h00} : payload_word;
	assign pay_sum      = acc_q + {16'h0000, pay_w};

	// Per-request update of the packet state and the result
	always_comb begin
		acc_d        = acc_q;
		bytes_left_d = bytes_left_q;
		held_tot_d   = held_tot_q;
		held_ipc_d   = held_ipc_q;
		emit         = 1'b0;
		r_changed    = 1'b0;
		r_short      = 1'b0;
		r_tot        = held_tot_q;
		r_ipc        = held_ipc_q;
		r_udp        = 16'h0000;
		unique case (opcode_s1)
			ulcu_pkg::OP_HEADER: begin
				acc_d        = 32'h0;
				bytes_left_d = 16'h0;
				if (calc.same_len) begin
					emit  = 1'b1;
					r_tot = tdata_s1[79:64];
					r_ipc = tdata_s1[95:80];
				end else begin
					acc_d      = {{(32-ulcu_pkg::SEED_W){1'b0}}, calc.seed};
					held_tot_d = calc.new_tot;
					held_ipc_d = calc.ip_csum;
					r_changed  = 1'b1;
					r_tot      = calc.new_tot;
					r_ipc      = calc.ip_csum;
					if (calc.too_short) begin
						emit    = 1'b1;
						r_short = 1'b1;
					end else if (calc.no_payload) begin
						emit  = 1'b1;
						r_udp = ulcu_pkg::udp_finish(
							{{(32-ulcu_pkg::SEED_W){1'b0}}, calc.seed});
					end else begin
						bytes_left_d = calc.payload_bytes;
					end
				end
			end
			ulcu_pkg::OP_PAYLOAD: begin
				if (bytes_left_q != 16'h0) begin
					acc_d        = pay_sum;
					bytes_left_d = (bytes_left_q >= 16'd2) ? bytes_left_q - 16'd2 : 16'h0;
					if (bytes_left_q <= 16'd2) begin
						emit      = 1'b1;
						r_changed = 1'b1;
						r_udp     = ulcu_pkg::udp_finish(pay_sum);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Packet state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= 32'h0;
			bytes_left_q <= 16'h0;
			held_tot_q   <= 16'h0;
			held_ipc_q   <= 16'h0;
		end else if (fire_s1) begin
			acc_q        <= acc_d;
			bytes_left_q <= bytes_left_d;
			held_tot_q   <= held_tot_d;
			held_ipc_q   <= held_ipc_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			m_data_q <= {r_udp, r_ipc, r_tot};
			m_user_q <= {r_short, r_changed};
		end
	end

	// A short result is always a changed one with no UDP checksum
	`ULCU_ASSERT(a_short_result, clk, arst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && m_axis_tdata[47:32] == 16'h0000)
	// A finished UDP checksum is never sent as zero
	`ULCU_ASSERT_NEVER(a_zero_udp_csum, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1] && m_axis_tdata[47:32] == 16'h0000)
	// A result closes the packet: nothing left outstanding afterwards
	`ULCU_ASSERT(a_emit_closes, clk, arst_n, fire_s1 && emit |=> bytes_left_q == 16'h0)
	// A stalled input register keeps its request
	`ULCU_ASSERT(a_s1_hold, clk, arst_n, valid_s1 && !advance |=> valid_s1 && $stable(tdata_s1) && $stable(opcode_s1))

endmodule
